@@ hdl/pixel_alpha_tint_compositor_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pixel alpha tint compositor.
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ALPHA_TINT_COMPOSITOR_MACROS_SVH
`define PIXEL_ALPHA_TINT_COMPOSITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PATC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compositor check failed");

// The consequent must hold in the cycle after the antecedent.
`define PATC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compositor check failed");

`endif

@@ hdl/patc_pkg.sv @@
// ----------------------------------------------------------------------------
// patc_pkg
// Shared constants and arithmetic helpers of the pixel alpha tint compositor.
// ----------------------------------------------------------------------------
package patc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned ProdW   = 2 * ChanW;
  localparam int unsigned NumChan = 3;   // 0 blue, 1 green, 2 red
  localparam int unsigned CfgIdxW = 3;

  // Mode codes.
  localparam logic [1:0] CMD_BLEND  = 2'd0;
  localparam logic [1:0] CMD_TINT   = 2'd1;
  localparam logic [1:0] CMD_COPY   = 2'd2;
  localparam logic [1:0] CMD_INVERT = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_OPACITY    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TINT_RED   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TINT_GREEN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TINT_BLUE  = 3'd3;

  localparam logic [ChanW-1:0] CHAN_MAX = 8'd255;

  // How the final stage forms a channel.
  localparam logic [2:0] KIND_SHIFT = 3'd0;  // mixed sum shifted right by 8
  localparam logic [2:0] KIND_DIV   = 3'd1;  // mixed sum divided by 255
  localparam logic [2:0] KIND_SRC   = 3'd2;  // source passes through
  localparam logic [2:0] KIND_DST   = 3'd3;  // destination passes through
  localparam logic [2:0] KIND_INV   = 3'd4;  // destination inverted

  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;
  typedef logic [NumChan-1:0][ProdW-1:0] prod_t;

  // Exact floor(x / 255) for any x up to 255 * 255, with two adds and a shift.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

@@ hdl/pixel_alpha_tint_compositor.sv @@
// ----------------------------------------------------------------------------
// pixel_alpha_tint_compositor
// Four-stage pipelined BGR888 compositor with blend, tint, copy and invert
// modes. One item enters per clock while in_stall_o is low. Items flow
// through four register stages: the first forms the source-by-tint and
// alpha-by-opacity products, the second reduces them to the tinted source
// and the effective opacity and decides how the pixel is formed, the third
// forms the destination and source weight products, and the fourth adds
// them and scales the sum by 1/256 or 1/255, or passes the source or the
// destination through or inverts the destination, and holds the result for
// the consumer. The sustained rate is one item per cycle while the output
// is not stalled, because every stage can take a new item as soon as it
// hands its own on. A stall on the output freezes only the full stages in
// front of it, so bubbles are squeezed out and the input keeps accepting
// until every stage holds an item. The opacity and tint registers reset to
// 255 and are meant to be written only while no item is in flight.
// ----------------------------------------------------------------------------
`include "pixel_alpha_tint_compositor_macros.svh"

module pixel_alpha_tint_compositor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input item channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [patc_pkg::ChanW-1:0]     dst_blue_i,
  input  logic [patc_pkg::ChanW-1:0]     dst_green_i,
  input  logic [patc_pkg::ChanW-1:0]     dst_red_i,
  input  logic [patc_pkg::ChanW-1:0]     src_blue_i,
  input  logic [patc_pkg::ChanW-1:0]     src_green_i,
  input  logic [patc_pkg::ChanW-1:0]     src_red_i,
  input  logic [patc_pkg::ChanW-1:0]     src_alpha_i,
  input  logic                           src_has_alpha_i,
  // Result item channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [patc_pkg::ChanW-1:0]     out_blue_o,
  output logic [patc_pkg::ChanW-1:0]     out_green_o,
  output logic [patc_pkg::ChanW-1:0]     out_red_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [patc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [patc_pkg::ChanW-1:0]     cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always accepted; an index
  // beyond the register list is accepted and ignored.
  // --------------------------------------------------------------------------
  logic [patc_pkg::ChanW-1:0] opacity_q;
  patc_pkg::pixel_t           tint_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= patc_pkg::CHAN_MAX;
      tint_q    <= {patc_pkg::NumChan{patc_pkg::CHAN_MAX}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        patc_pkg::REG_OPACITY:    opacity_q <= cfg_data_i;
        patc_pkg::REG_TINT_RED:   tint_q[2] <= cfg_data_i;
        patc_pkg::REG_TINT_GREEN: tint_q[1] <= cfg_data_i;
        patc_pkg::REG_TINT_BLUE:  tint_q[0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage may load when it is empty or when the
  // stage after it is loading too.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: source times tint per channel, and alpha times opacity.
  // --------------------------------------------------------------------------
  patc_pkg::pixel_t           in_dst, in_src;
  logic [1:0]                 s1_cmd_q;
  logic                       s1_has_alpha_q;
  logic [patc_pkg::ChanW-1:0] s1_opacity_q;
  patc_pkg::pixel_t           s1_dst_q, s1_src_q;
  patc_pkg::prod_t            s1_stint_q;
  logic [patc_pkg::ProdW-1:0] s1_aop_q;

  assign in_dst = {dst_red_i, dst_green_i, dst_blue_i};
  assign in_src = {src_red_i, src_green_i, src_blue_i};

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_cmd_q       <= cmd_i;
      s1_has_alpha_q <= src_has_alpha_i;
      s1_opacity_q   <= opacity_q;
      s1_dst_q       <= in_dst;
      s1_src_q       <= in_src;
      for (int k = 0; k < patc_pkg::NumChan; k++) begin
        s1_stint_q[k] <= patc_pkg::ProdW'(in_src[k]) * patc_pkg::ProdW'(tint_q[k]);
      end
      s1_aop_q <= patc_pkg::ProdW'(src_alpha_i) * patc_pkg::ProdW'(opacity_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: effective opacity, tinted source and the way the pixel is formed.
  // --------------------------------------------------------------------------
  logic [patc_pkg::ChanW-1:0] s2_op_d;
  logic [2:0]                 s2_kind_d;
  patc_pkg::pixel_t           s2_mixsrc_d;

  always_comb begin
    if (s1_cmd_q == patc_pkg::CMD_TINT) begin
      s2_op_d = s1_has_alpha_q ? patc_pkg::div255(s1_aop_q) : s1_opacity_q;
      for (int k = 0; k < patc_pkg::NumChan; k++) begin
        s2_mixsrc_d[k] = patc_pkg::div255(s1_stint_q[k]);
      end
    end else begin
      s2_op_d = s1_has_alpha_q ? s1_aop_q[patc_pkg::ProdW-1:patc_pkg::ChanW] : s1_opacity_q;
      s2_mixsrc_d = s1_src_q;
    end

    case (s1_cmd_q)
      patc_pkg::CMD_COPY:   s2_kind_d = patc_pkg::KIND_SRC;
      patc_pkg::CMD_INVERT: s2_kind_d = patc_pkg::KIND_INV;
      patc_pkg::CMD_TINT: begin
        s2_kind_d = (s1_opacity_q == '0) ? patc_pkg::KIND_DST : patc_pkg::KIND_DIV;
      end
      default: begin
        if (s1_opacity_q == '0) begin
          s2_kind_d = patc_pkg::KIND_DST;
        end else if (!s1_has_alpha_q && s1_opacity_q == patc_pkg::CHAN_MAX) begin
          // Full opacity without alpha is an exact copy of the source.
          s2_kind_d = patc_pkg::KIND_SRC;
        end else begin
          s2_kind_d = patc_pkg::KIND_SHIFT;
        end
      end
    endcase
  end

  logic [patc_pkg::ChanW-1:0] s2_op_q;
  logic [2:0]                 s2_kind_q;
  patc_pkg::pixel_t           s2_dst_q, s2_src_q, s2_mixsrc_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_op_q     <= s2_op_d;
      s2_kind_q   <= s2_kind_d;
      s2_dst_q    <= s1_dst_q;
      s2_src_q    <= s1_src_q;
      s2_mixsrc_q <= s2_mixsrc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: destination and source weight products per channel.
  // --------------------------------------------------------------------------
  logic [2:0]       s3_kind_q;
  patc_pkg::pixel_t s3_dst_q, s3_src_q;
  patc_pkg::prod_t  s3_pd_q, s3_ps_q;
  logic [patc_pkg::ChanW-1:0] s2_inv_op;

  assign s2_inv_op = patc_pkg::CHAN_MAX - s2_op_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_kind_q <= s2_kind_q;
      s3_dst_q  <= s2_dst_q;
      s3_src_q  <= s2_src_q;
      for (int k = 0; k < patc_pkg::NumChan; k++) begin
        s3_pd_q[k] <= patc_pkg::ProdW'(s2_dst_q[k]) * patc_pkg::ProdW'(s2_inv_op);
        s3_ps_q[k] <= patc_pkg::ProdW'(s2_mixsrc_q[k]) * patc_pkg::ProdW'(s2_op_q);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum, scale and select; this register faces the consumer.
  // The sum never exceeds 255 * 255, so 16 bits hold it.
  // --------------------------------------------------------------------------
  patc_pkg::pixel_t s4_res_d, s4_res_q;

  always_comb begin
    logic [patc_pkg::ProdW:0] sum;
    for (int k = 0; k < patc_pkg::NumChan; k++) begin
      sum = {1'b0, s3_pd_q[k]} + {1'b0, s3_ps_q[k]};
      case (s3_kind_q)
        patc_pkg::KIND_SHIFT: s4_res_d[k] = sum[patc_pkg::ProdW-1:patc_pkg::ChanW];
        patc_pkg::KIND_DIV:   s4_res_d[k] = patc_pkg::div255(sum[patc_pkg::ProdW-1:0]);
        patc_pkg::KIND_SRC:   s4_res_d[k] = s3_src_q[k];
        patc_pkg::KIND_INV:   s4_res_d[k] = ~s3_dst_q[k];
        default:              s4_res_d[k] = s3_dst_q[k];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      s4_res_q <= s4_res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_blue_o  = s4_res_q[0];
  assign out_green_o = s4_res_q[1];
  assign out_red_o   = s4_res_q[2];

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The input is held off only when every stage holds an item.
  `PATC_ASSERT_SAME(a_stall_only_when_full, in_stall_o, v1_q && v2_q && v3_q && v4_q)
  // A result held by the consumer is still present in the next cycle.
  `PATC_ASSERT_NEXT(a_held_result_kept, v4_q && out_stall_i, v4_q && $stable(s4_res_q))
  // An opacity write lands in the register.
  `PATC_ASSERT_NEXT(a_opacity_write,
    cfg_valid_i && cfg_ready_o && cfg_index_i == patc_pkg::REG_OPACITY,
    opacity_q == $past(cfg_data_i))

endmodule

@@ sim/pixel_alpha_tint_compositor_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_alpha_tint_compositor_tb
// Self-checking bench for the BGR888 compositor. A directed pass walks every
// mode and the corner cases, and a random pass follows with about 1300 pixels.
// Each accepted pixel goes to a scoreboard that computes the new destination
// pixel, and each returned pixel is checked against it in order. The opacity
// and tint registers are rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module pixel_alpha_tint_compositor_tb;

  localparam int unsigned FULL_SCALE   = 255;
  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 11;
  // Four pipe stages plus margin; used before register writes and at the end.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_CHUNK = 160;
  // Far beyond the slowest legal run, even with heavy stalls.
  localparam int unsigned RUN_LIMIT    = 3_000_000;

  // One input item: destination pixel, source pixel, alpha and mode.
  typedef struct {
    logic [1:0]                 cmd;
    patc_pkg::pixel_t           dst;
    patc_pkg::pixel_t           src;
    logic [patc_pkg::ChanW-1:0] alpha;
    logic                       has_alpha;
  } pixel_job_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the registers, turns every accepted
  // item into the pixel the block must return and compares in arrival order.
  // --------------------------------------------------------------------------
  class composite_scoreboard;
    logic [patc_pkg::ChanW-1:0] opacity;
    patc_pkg::pixel_t           tint;        // 0 blue, 1 green, 2 red
    patc_pkg::pixel_t           expected_q[$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                mode_count[4];

    function new();
      opacity = patc_pkg::CHAN_MAX;
      tint    = {patc_pkg::CHAN_MAX, patc_pkg::CHAN_MAX, patc_pkg::CHAN_MAX};
      errors  = 0;
      checked = 0;
      foreach (mode_count[m]) mode_count[m] = 0;
    endfunction

    // Indexes past the tint registers are ignored by the block.
    function void write_reg(logic [patc_pkg::CfgIdxW-1:0] idx,
                            logic [patc_pkg::ChanW-1:0] data);
      case (idx)
        patc_pkg::REG_OPACITY:    opacity = data;
        patc_pkg::REG_TINT_RED:   tint[2] = data;
        patc_pkg::REG_TINT_GREEN: tint[1] = data;
        patc_pkg::REG_TINT_BLUE:  tint[0] = data;
        default: ;
      endcase
    endfunction

    function patc_pkg::pixel_t composite(pixel_job_t j);
      patc_pkg::pixel_t r;
      int unsigned      o, a, op, d, s, ts;
      int               k;
      o = opacity;
      a = j.alpha;
      r = j.dst;
      case (j.cmd)
        patc_pkg::CMD_COPY:   r = j.src;
        patc_pkg::CMD_INVERT: begin
          for (k = 0; k < patc_pkg::NumChan; k++) r[k] = patc_pkg::CHAN_MAX - j.dst[k];
        end
        default: begin
          // Zero opacity leaves the destination untouched in both mix modes.
          if (o != 0) begin
            if (j.cmd == patc_pkg::CMD_BLEND) begin
              if (!j.has_alpha && o == FULL_SCALE) begin
                // Full opacity without alpha is an exact copy, not the formula.
                r = j.src;
              end else begin
                op = j.has_alpha ? (a * o) >> 8 : o;
                for (k = 0; k < patc_pkg::NumChan; k++) begin
                  d    = j.dst[k];
                  s    = j.src[k];
                  r[k] = patc_pkg::ChanW'((d * (FULL_SCALE - op) + s * op) >> 8);
                end
              end
            end else begin
              // Tint scales the source first and divides by 255 throughout.
              op = j.has_alpha ? (a * o) / FULL_SCALE : o;
              for (k = 0; k < patc_pkg::NumChan; k++) begin
                d    = j.dst[k];
                ts   = (j.src[k] * tint[k]) / FULL_SCALE;
                r[k] = patc_pkg::ChanW'((d * (FULL_SCALE - op) + ts * op) / FULL_SCALE);
              end
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_input(pixel_job_t j);
      mode_count[j.cmd]++;
      expected_q.push_back(composite(j));
    endfunction

    function void check_result(patc_pkg::pixel_t got);
      patc_pkg::pixel_t want;
      string            chan_name[patc_pkg::NumChan];
      int               k;
      chan_name = '{"out_blue", "out_green", "out_red"};
      if (expected_q.size() == 0) begin
        $error("result pixel %06h arrived with nothing pending", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      for (k = 0; k < patc_pkg::NumChan; k++) begin
        if (got[k] !== want[k]) begin
          $error("%s: expected %0d, got %0d", chan_name[k], want[k], got[k]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   cmd_i           = patc_pkg::CMD_BLEND;
  logic [patc_pkg::ChanW-1:0]   dst_blue_i      = '0;
  logic [patc_pkg::ChanW-1:0]   dst_green_i     = '0;
  logic [patc_pkg::ChanW-1:0]   dst_red_i       = '0;
  logic [patc_pkg::ChanW-1:0]   src_blue_i      = '0;
  logic [patc_pkg::ChanW-1:0]   src_green_i     = '0;
  logic [patc_pkg::ChanW-1:0]   src_red_i       = '0;
  logic [patc_pkg::ChanW-1:0]   src_alpha_i     = '0;
  logic                         src_has_alpha_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  logic [patc_pkg::ChanW-1:0]   out_blue_o;
  logic [patc_pkg::ChanW-1:0]   out_green_o;
  logic [patc_pkg::ChanW-1:0]   out_red_o;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [patc_pkg::CfgIdxW-1:0] cfg_index_i     = '0;
  logic [patc_pkg::ChanW-1:0]   cfg_data_i      = '0;

  always #HALF_PERIOD clk_i = ~clk_i;

  pixel_alpha_tint_compositor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .dst_blue_i      (dst_blue_i),
    .dst_green_i     (dst_green_i),
    .dst_red_i       (dst_red_i),
    .src_blue_i      (src_blue_i),
    .src_green_i     (src_green_i),
    .src_red_i       (src_red_i),
    .src_alpha_i     (src_alpha_i),
    .src_has_alpha_i (src_has_alpha_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_blue_o      (out_blue_o),
    .out_green_o     (out_green_o),
    .out_red_o       (out_red_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  composite_scoreboard pixel_sb = new();

  // Idle and stall rates of the current phase, in percent.
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned setting_count = 0;

  function automatic bit roll_gap(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall is driven at the falling edge, and a pixel is taken
  // at the rising edge where valid is high and stall is low.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= roll_gap(stall_pct);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        pixel_sb.check_result({out_red_o, out_green_o, out_blue_o});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Each task is entered and left at a falling edge, and valid
  // gets a single assignment per falling edge.
  // --------------------------------------------------------------------------
  task automatic push_pixel(input pixel_job_t j);
    while (roll_gap(idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= j.cmd;
    dst_blue_i      <= j.dst[0];
    dst_green_i     <= j.dst[1];
    dst_red_i       <= j.dst[2];
    src_blue_i      <= j.src[0];
    src_green_i     <= j.src[1];
    src_red_i       <= j.src[2];
    src_alpha_i     <= j.alpha;
    src_has_alpha_i <= j.has_alpha;
    // The payload holds still until the item is taken.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixel_sb.note_input(j);
    @(negedge clk_i);
  endtask

  // Stops sending, lets every pending pixel come back, then lets the pipe
  // settle so that register writes never overlap an item in flight.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pixel_sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [patc_pkg::CfgIdxW-1:0] idx,
                           input logic [patc_pkg::ChanW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pixel_sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Writes all four registers, then one index past the last register, which
  // the block must ignore. Valid drops once, after the final write.
  task automatic apply_setting(input logic [patc_pkg::ChanW-1:0] op,
                               input logic [patc_pkg::ChanW-1:0] red,
                               input logic [patc_pkg::ChanW-1:0] green,
                               input logic [patc_pkg::ChanW-1:0] blue);
    logic [patc_pkg::CfgIdxW-1:0] spare_idx;
    spare_idx = patc_pkg::REG_TINT_BLUE + patc_pkg::CfgIdxW'($urandom_range(4, 1));
    write_reg(patc_pkg::REG_OPACITY, op);
    write_reg(patc_pkg::REG_TINT_RED, red);
    write_reg(patc_pkg::REG_TINT_GREEN, green);
    write_reg(patc_pkg::REG_TINT_BLUE, blue);
    write_reg(spare_idx, patc_pkg::ChanW'($urandom));
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  function automatic pixel_job_t make_job(logic [1:0] cmd, patc_pkg::pixel_t dst,
                                          patc_pkg::pixel_t src,
                                          logic [patc_pkg::ChanW-1:0] alpha,
                                          logic has_alpha);
    pixel_job_t j;
    j.cmd       = cmd;
    j.dst       = dst;
    j.src       = src;
    j.alpha     = alpha;
    j.has_alpha = has_alpha;
    return j;
  endfunction

  // Channel values lean toward the extremes, where rounding errors show.
  function automatic logic [patc_pkg::ChanW-1:0] pick_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return patc_pkg::CHAN_MAX;
      default: return patc_pkg::ChanW'($urandom);
    endcase
  endfunction

  function automatic pixel_job_t random_job();
    pixel_job_t j;
    int         k;
    j.cmd = 2'($urandom_range(3));
    for (k = 0; k < patc_pkg::NumChan; k++) begin
      j.dst[k] = pick_chan();
      j.src[k] = pick_chan();
    end
    j.alpha     = pick_chan();
    j.has_alpha = 1'($urandom);
    return j;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned                phase_idle[4];
    int unsigned                phase_stall[4];
    int                         p, c, n;
    logic [patc_pkg::ChanW-1:0] op_pick;

    phase_idle  = '{0, 83, 0, 8};
    phase_stall = '{0, 0, 83, 8};

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values: opacity and tint all 255.
    // Blend without alpha at full opacity must be a plain copy, and alpha
    // must be ignored while its flag is clear.
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'h000000, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'hFFFFFF, 24'h000000, 8'hAB, 1'b0));
    // With alpha, full opacity goes through the shift formula.
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'h123456, 24'hFEDCBA, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'hFFFFFF, 24'h000000, 8'h00, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_TINT,  24'h000000, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_TINT,  24'hFFFFFF, 24'h000000, 8'h80, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_COPY,  24'hFFFFFF, 24'h000000, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_COPY,  24'h000000, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_INVERT, 24'h000000, 24'hFFFFFF, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_INVERT, 24'hFFFFFF, 24'h000000, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_INVERT, 24'h5A3CC3, 24'hA5C33C, 8'h5A, 1'b0));
    drain_pipe();

    // Zero opacity: both mix modes return the destination, alpha or not,
    // while copy and invert ignore opacity and tint.
    apply_setting(8'h00, 8'h40, 8'h80, 8'hC0);
    push_pixel(make_job(patc_pkg::CMD_BLEND,  24'h13579B, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_BLEND,  24'hFEDCBA, 24'h000000, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_TINT,   24'h2468AC, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_TINT,   24'hFFFFFF, 24'h000000, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_COPY,   24'h000000, 24'h9ABCDE, 8'h77, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_INVERT, 24'h0F1E2D, 24'hFFFFFF, 8'hFF, 1'b1));
    drain_pipe();

    // Mid opacity with tint channels at zero, full and one.
    apply_setting(8'h80, 8'h00, 8'hFF, 8'h01);
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'h000000, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_BLEND, 24'hFFFFFF, 24'h000000, 8'hFF, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_TINT,  24'h000000, 24'hFFFFFF, 8'h00, 1'b0));
    push_pixel(make_job(patc_pkg::CMD_TINT,  24'h808080, 24'hFFFFFF, 8'h7F, 1'b1));
    push_pixel(make_job(patc_pkg::CMD_TINT,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, 1'b1));
    drain_pipe();

    // Random pass: four idle/stall phases, each split into two chunks with
    // their own register setting. Opacity hits 255, 0, 1 and 254 before it
    // turns random; tint channels lean toward 0 and 255.
    n = 0;
    for (p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (c = 0; c < 2; c++) begin
        case (n)
          0:       op_pick = patc_pkg::CHAN_MAX;
          1:       op_pick = '0;
          2:       op_pick = 8'd1;
          3:       op_pick = patc_pkg::CHAN_MAX - 8'd1;
          default: op_pick = pick_chan();
        endcase
        apply_setting(op_pick, pick_chan(), pick_chan(), pick_chan());
        repeat (RANDOM_CHUNK) push_pixel(random_job());
        drain_pipe();
        n++;
      end
    end

    // drain_pipe has already waited out the pipe latency; anything left
    // over or arriving late is a failure.
    if (pixel_sb.pending() != 0) begin
      $error("%0d expected pixels never arrived", pixel_sb.pending());
      pixel_sb.errors++;
    end

    $display("Checked %0d pixels under %0d register settings and four idle/stall mixes.",
             pixel_sb.checked, setting_count);
    $display("Modes seen: blend %0d, tint %0d, copy %0d, invert %0d.",
             pixel_sb.mode_count[patc_pkg::CMD_BLEND],
             pixel_sb.mode_count[patc_pkg::CMD_TINT],
             pixel_sb.mode_count[patc_pkg::CMD_COPY],
             pixel_sb.mode_count[patc_pkg::CMD_INVERT]);
    if (pixel_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT * 2 * HALF_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
